// ----- hdl/ntcat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ntcat_pkg;

    // Group size and fixed widths.
    localparam int AVG_SAMPLES = 8;
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 15;
    localparam int COUNT_W     = 3;
    localparam int OHMS_W      = 20;
    localparam int BETA_W      = 14;
    localparam int TEMP_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 2;

    // Shared divider sizes.
    localparam int DVD_W = 54;
    localparam int DVS_W = 39;

    // Logarithm and beta equation constants.
    localparam int LN_W  = 21;
    localparam int LNX_W = 32;
    localparam int EX_W  = 5;
    localparam logic [SAMPLE_W-1:0] ADC_TOP        = 12'd4095;
    localparam logic [15:0]         SERIES_OHMS    = 16'd5100;
    localparam logic [15:0]         LN2_Q16        = 16'd45426;
    localparam logic [14:0]         T0_CENTIK      = 15'd29815;
    localparam logic [22:0]         SCALE_Q16_CENTI = 23'd6553600;
    localparam logic [15:0]         ICE_CENTIK     = 16'd27315;
    localparam logic [15:0]         CK_HIGH        = 16'd47315;
    localparam logic [15:0]         CK_LOW         = 16'd17315;
    localparam logic signed [TEMP_W-1:0] SAT_HI_CENTI = 16'sd20000;
    localparam logic signed [TEMP_W-1:0] SAT_LO_CENTI = -16'sd10000;

    // Register indexes.
    localparam logic [INDEX_W-1:0] REG_PULLUP  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_NOMINAL = 2'd1;
    localparam logic [INDEX_W-1:0] REG_BETA    = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADC     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RNONPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

    // Result kinds chosen by the controller.
    localparam logic [1:0] RES_ADC  = 2'd0;
    localparam logic [1:0] RES_RES  = 2'd1;
    localparam logic [1:0] RES_DSAT = 2'd2;
    localparam logic [1:0] RES_CALC = 2'd3;

    typedef struct packed {
        logic       acc;
        logic       div_up;
        logic       div_temp;
        logic       ln_load_r;
        logic       ln_load_nom;
        logic       ln_shift;
        logic       ln_store_a;
        logic       ln_store_b;
        logic       den1;
        logic       den2;
        logic       load_out;
        logic [1:0] res_kind;
    } ntcat_cmd_t;

    typedef struct packed {
        logic last;
        logic adc_limit;
        logic div_busy;
        logic r_nonpos;
        logic ln_norm;
        logic den_nonpos;
        logic out_busy;
    } ntcat_stat_t;

    // round(65536*ln(1+k/16)) for k = 0..16.
    function automatic logic [15:0] ln_mant(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3973;
            5'd2:  v = 16'd7719;
            5'd3:  v = 16'd11262;
            5'd4:  v = 16'd14624;
            5'd5:  v = 16'd17821;
            5'd6:  v = 16'd20870;
            5'd7:  v = 16'd23783;
            5'd8:  v = 16'd26573;
            5'd9:  v = 16'd29248;
            5'd10: v = 16'd31818;
            5'd11: v = 16'd34292;
            5'd12: v = 16'd36675;
            5'd13: v = 16'd38975;
            5'd14: v = 16'd41196;
            5'd15: v = 16'd43345;
            5'd16: v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ntcat_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ntcat_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ntcat_pkg::DVD_W-1:0] dividend,
    input  wire logic [ntcat_pkg::DVS_W-1:0] divisor,
    output logic                             busy,
    output logic [ntcat_pkg::DVD_W-1:0]      quotient
);
    import ntcat_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;

    // One restoring step per cycle, MSB first.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[DVS_W-1:0], q_reg[DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- hdl/ntcat_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ntcat_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ntcat_pkg::ntcat_cmd_t              cmd,
    output ntcat_pkg::ntcat_stat_t                  stat,
    input  wire logic [ntcat_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic                               cfg_valid,
    input  wire logic [ntcat_pkg::INDEX_W-1:0]      cfg_index,
    input  wire logic [ntcat_pkg::OHMS_W-1:0]       cfg_data,
    input  wire logic                               result_ready,
    output logic                                    result_valid,
    output logic [ntcat_pkg::SAMPLE_W-1:0]          mean_sample,
    output logic signed [ntcat_pkg::TEMP_W-1:0]     temperature_centi,
    output logic [ntcat_pkg::STATUS_W-1:0]          status
);
    import ntcat_pkg::*;

    logic [OHMS_W-1:0]   pullup_reg, nominal_reg;
    logic [BETA_W-1:0]   beta_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [LNX_W-1:0]    x_reg;
    logic [EX_W-1:0]     ex_reg;
    logic [LN_W-1:0]     lna_reg, lnb_reg;
    logic [36:0]         bks_reg;
    logic signed [37:0]  lt_reg;
    logic signed [39:0]  den_reg;
    logic [51:0]         num_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_mean_reg;
    logic signed [TEMP_W-1:0]   out_temp_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [SUM_W-1:0]    sum_next;
    logic [OHMS_W-1:0]   nom_eff;
    logic [BETA_W-1:0]   beta_eff;
    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    logic                div_busy;
    logic [DVD_W-1:0]    div_q;
    logic [15:0]         frac;
    logic [15:0]         ln_lo, ln_hi;
    logic [11:0]         ln_step;
    logic [23:0]         ln_prod;
    logic [LN_W-1:0]     ln_val;
    logic signed [LN_W:0] ln_diff;
    logic [STATUS_W-1:0] res_status;
    logic signed [TEMP_W-1:0] res_temp;

    assign nom_eff  = (nominal_reg == '0) ? OHMS_W'(1) : nominal_reg;
    assign beta_eff = (beta_reg == '0) ? BETA_W'(1) : beta_reg;
    assign sum_next = sum_reg + SUM_W'(sample);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pullup_reg  <= OHMS_W'(10000);
            nominal_reg <= OHMS_W'(10000);
            beta_reg    <= BETA_W'(3950);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PULLUP:  pullup_reg  <= cfg_data;
                REG_NOMINAL: nominal_reg <= cfg_data;
                REG_BETA:    beta_reg    <= cfg_data[BETA_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample accumulation over one group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (count_reg == COUNT_W'(AVG_SAMPLES - 1))
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc && count_reg == COUNT_W'(AVG_SAMPLES - 1))
        begin
            mean_reg <= SAMPLE_W'(sum_next / AVG_SAMPLES);
        end
    end

    // Divider operands: pull-up ratio first, temperature second.
    assign div_start = cmd.div_up | cmd.div_temp;
    always_comb
    begin
        if (cmd.div_temp)
        begin
            div_dvd = DVD_W'(num_reg) + DVD_W'(den_reg[39:1]);
            div_dvs = den_reg[DVS_W-1:0];
        end
        else
        begin
            div_dvd = DVD_W'(pullup_reg * mean_reg);
            div_dvs = DVS_W'(ADC_TOP - mean_reg);
        end
    end

    ntcat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Logarithm: normalize one bit a cycle, then table plus interpolation.
    // Adjacent table entries differ by less than 4096, so the step fits 12 bits.
    assign frac    = x_reg[30:15];
    assign ln_lo   = ln_mant({1'b0, frac[15:12]});
    assign ln_hi   = ln_mant({1'b0, frac[15:12]} + 5'd1);
    assign ln_step = 12'(ln_hi - ln_lo);
    assign ln_prod = ln_step * frac[11:0];
    assign ln_val  = LN_W'(ex_reg * LN2_Q16) + LN_W'(ln_lo) + LN_W'(ln_prod[23:12]);

    always_ff @(posedge clk)
    begin
        if (cmd.ln_load_r)
        begin
            x_reg  <= div_q[LNX_W-1:0] - LNX_W'(SERIES_OHMS);
            ex_reg <= EX_W'(LNX_W - 1);
        end
        else if (cmd.ln_load_nom)
        begin
            x_reg  <= LNX_W'(nom_eff);
            ex_reg <= EX_W'(LNX_W - 1);
        end
        else if (cmd.ln_shift)
        begin
            x_reg  <= {x_reg[LNX_W-2:0], 1'b0};
            ex_reg <= ex_reg - 1'b1;
        end
        if (cmd.ln_store_a)
        begin
            lna_reg <= ln_val;
        end
        if (cmd.ln_store_b)
        begin
            lnb_reg <= ln_val;
        end
    end

    // Beta equation denominator and numerator.
    assign ln_diff = $signed({1'b0, lna_reg}) - $signed({1'b0, lnb_reg});
    always_ff @(posedge clk)
    begin
        if (cmd.den1)
        begin
            bks_reg <= 37'(beta_eff * SCALE_Q16_CENTI);
            lt_reg  <= 38'($signed({1'b0, T0_CENTIK}) * ln_diff);
        end
        if (cmd.den2)
        begin
            den_reg <= $signed({3'b0, bks_reg}) + 40'(lt_reg);
            num_reg <= 52'(bks_reg * T0_CENTIK);
        end
    end

    // Result fields for each kind of outcome.
    always_comb
    begin
        res_status = ST_OK;
        res_temp   = '0;
        case (cmd.res_kind)
            RES_ADC:  res_status = ST_ADC;
            RES_RES:  res_status = ST_RNONPOS;
            RES_DSAT:
            begin
                res_status = ST_SAT;
                res_temp   = SAT_HI_CENTI;
            end
            RES_CALC:
            begin
                if (div_q > DVD_W'(CK_HIGH))
                begin
                    res_status = ST_SAT;
                    res_temp   = SAT_HI_CENTI;
                end
                else if (div_q < DVD_W'(CK_LOW))
                begin
                    res_status = ST_SAT;
                    res_temp   = SAT_LO_CENTI;
                end
                else
                begin
                    res_temp = $signed(div_q[TEMP_W-1:0] - ICE_CENTIK);
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mean_reg   <= mean_reg;
            out_temp_reg   <= res_temp;
            out_status_reg <= res_status;
        end
    end

    assign result_valid      = out_valid_reg;
    assign mean_sample       = out_mean_reg;
    assign temperature_centi = out_temp_reg;
    assign status            = out_status_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.last       = (count_reg == COUNT_W'(AVG_SAMPLES - 1));
        stat.adc_limit  = (mean_reg == '0) || (mean_reg >= ADC_TOP);
        stat.div_busy   = div_busy;
        stat.r_nonpos   = (div_q <= DVD_W'(SERIES_OHMS));
        stat.ln_norm    = x_reg[LNX_W-1];
        stat.den_nonpos = den_reg[39] || (den_reg == '0);
        stat.out_busy   = out_valid_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/ntcat_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ntcat_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire ntcat_pkg::ntcat_stat_t stat,
    output ntcat_pkg::ntcat_cmd_t       cmd
);
    import ntcat_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_RES   = 4'd3;
    localparam logic [3:0] S_LNA   = 4'd4;
    localparam logic [3:0] S_LNBL  = 4'd5;
    localparam logic [3:0] S_LNB   = 4'd6;
    localparam logic [3:0] S_DEN1  = 4'd7;
    localparam logic [3:0] S_DEN2  = 4'd8;
    localparam logic [3:0] S_DCHK  = 4'd9;
    localparam logic [3:0] S_DIV2  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    // Sequencer for one group conversion.
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.res_kind = kind_reg;
        sample_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.acc = 1'b1;
                    if (stat.last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.adc_limit)
                begin
                    kind_next  = RES_ADC;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_up = 1'b1;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (stat.r_nonpos)
                begin
                    kind_next  = RES_RES;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.ln_load_r = 1'b1;
                    state_next    = S_LNA;
                end
            end
            S_LNA:
            begin
                if (stat.ln_norm)
                begin
                    cmd.ln_store_a = 1'b1;
                    state_next     = S_LNBL;
                end
                else
                begin
                    cmd.ln_shift = 1'b1;
                end
            end
            S_LNBL:
            begin
                cmd.ln_load_nom = 1'b1;
                state_next      = S_LNB;
            end
            S_LNB:
            begin
                if (stat.ln_norm)
                begin
                    cmd.ln_store_b = 1'b1;
                    state_next     = S_DEN1;
                end
                else
                begin
                    cmd.ln_shift = 1'b1;
                end
            end
            S_DEN1:
            begin
                cmd.den1   = 1'b1;
                state_next = S_DEN2;
            end
            S_DEN2:
            begin
                cmd.den2   = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (stat.den_nonpos)
                begin
                    kind_next  = RES_DSAT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_temp = 1'b1;
                    state_next   = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (!stat.div_busy)
                begin
                    kind_next  = RES_CALC;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_ADC;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ntc_average_and_temperature.sv -----
// Throughput: one sample per cycle inside a group; after the last sample of a group no
// request is taken until the conversion ends (two 54-step divider passes, two
// one-bit-a-cycle log normalizations of up to 31 steps each), and longer while
// the previous result still waits to be taken.
// Reset: asynchronous, active low; clears the group sum and count, restores registers.
`timescale 1ns / 1ps
`default_nettype none

module ntc_average_and_temperature (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire logic [ntcat_pkg::SAMPLE_W-1:0]      sample,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic [ntcat_pkg::SAMPLE_W-1:0]           mean_sample,
    output logic signed [ntcat_pkg::TEMP_W-1:0]      temperature_centi,
    output logic [ntcat_pkg::STATUS_W-1:0]           status,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ntcat_pkg::INDEX_W-1:0]       cfg_index,
    input  wire logic [ntcat_pkg::OHMS_W-1:0]        cfg_data
);
    import ntcat_pkg::*;

    ntcat_cmd_t  cmd;
    ntcat_stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    ntcat_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    ntcat_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .sample            (sample),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result_ready      (result_ready),
        .result_valid      (result_valid),
        .mean_sample       (mean_sample),
        .temperature_centi (temperature_centi),
        .status            (status)
    );

endmodule

`default_nettype wire

// ----- dv/tb_ntc_average_and_temperature.sv -----
`timescale 1ns / 1ps

module tb_ntc_average_and_temperature;
    import ntcat_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [SAMPLE_W-1:0]      mean;
        logic signed [TEMP_W-1:0] temp;
        logic [STATUS_W-1:0]      st;
    } thermo_result_t;

    // round(65536*ln(1+k/16)) for k = 0..16.
    localparam int LN_STEPS [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
        26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [SAMPLE_W-1:0] mean_sample;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [STATUS_W-1:0] status;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [OHMS_W-1:0] cfg_data = '0;

    // Shadow registers and open group of the predictor.
    logic [OHMS_W-1:0] pullup_sh;
    logic [OHMS_W-1:0] nominal_sh;
    logic [BETA_W-1:0] beta_sh;
    logic [SUM_W-1:0] group_sum;
    int group_cnt;

    logic [SAMPLE_W-1:0] pending_samples[$];
    thermo_result_t expected_results[$];
    int n_launched = 0;
    int n_accepted = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    always #1 clk = ~clk;

    ntc_average_and_temperature dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample            (sample),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .mean_sample       (mean_sample),
        .temperature_centi (temperature_centi),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Natural log in Q.16 by table interpolation on the normalized mantissa.
    function automatic longint ln_q16(longint unsigned x);
        int ex;
        longint unsigned probe;
        longint unsigned frac;
        int idx;
        longint part;
        longint lo;
        longint hi;
        ex = 0;
        probe = x;
        while (probe > 1)
        begin
            probe = probe >> 1;
            ex++;
        end
        if (ex >= 16)
            frac = x >> (ex - 16);
        else
            frac = x << (16 - ex);
        frac = (frac - 65536) & 64'hFFFF;
        idx = int'(frac >> 12);
        part = longint'(frac & 64'hFFF);
        lo = LN_STEPS[idx];
        hi = LN_STEPS[idx + 1];
        return longint'(ex) * 45426 + lo + (((hi - lo) * part) >>> 12);
    endfunction

    // Temperature and status from the mean of one group.
    function automatic thermo_result_t convert_mean(logic [SAMPLE_W-1:0] mean);
        thermo_result_t r;
        longint rntc;
        longint rnom;
        longint bk;
        longint lq;
        longint den;
        longint num;
        longint ck;
        longint t;
        r.mean = mean;
        r.temp = '0;
        r.st = ST_OK;
        if (mean == 0 || mean == 12'd4095)
        begin
            r.st = ST_ADC;
        end
        else
        begin
            rntc = (longint'(pullup_sh) * mean) / (4095 - longint'(mean)) - 5100;
            if (rntc <= 0)
            begin
                r.st = ST_RNONPOS;
            end
            else
            begin
                rnom = (nominal_sh == 0) ? 1 : longint'(nominal_sh);
                bk = (beta_sh == 0) ? 1 : longint'(beta_sh);
                lq = ln_q16(rntc) - ln_q16(rnom);
                den = bk * 6553600 + 29815 * lq;
                if (den <= 0)
                begin
                    r.temp = SAT_HI_CENTI;
                    r.st = ST_SAT;
                end
                else
                begin
                    num = 29815 * bk * 6553600;
                    ck = (num + den / 2) / den;
                    t = ck - 27315;
                    if (t > 20000)
                    begin
                        r.temp = SAT_HI_CENTI;
                        r.st = ST_SAT;
                    end
                    else if (t < -10000)
                    begin
                        r.temp = SAT_LO_CENTI;
                        r.st = ST_SAT;
                    end
                    else
                    begin
                        r.temp = t[TEMP_W-1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Sample driver: holds a request until taken, idles at random between requests.
    always @(negedge clk)
    begin
        if (!sample_valid || n_accepted == n_launched)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                sample <= pending_samples.pop_front();
                sample_valid <= 1'b1;
                n_launched++;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
        result_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor: predicts on each accepted sample, checks each accepted result.
    always @(posedge clk)
    begin
        thermo_result_t want;
        if (rst_n && sample_valid && sample_ready)
        begin
            n_accepted++;
            group_sum = group_sum + SUM_W'(sample);
            group_cnt++;
            if (group_cnt == AVG_SAMPLES)
            begin
                expected_results.push_back(convert_mean(SAMPLE_W'(group_sum / AVG_SAMPLES)));
                group_sum = '0;
                group_cnt = 0;
            end
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, mean_sample", mean_sample, -1);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                status_seen[want.st]++;
                if (mean_sample !== want.mean)
                    report_mismatch("mean_sample", mean_sample, want.mean);
                if (temperature_centi !== want.temp)
                    report_mismatch("temperature_centi", temperature_centi, want.temp);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
            end
        end
        // Watchdog on progress of any channel.
        if ((sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("tb_ntc_average_and_temperature NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [OHMS_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PULLUP:  pullup_sh = value;
            REG_NOMINAL: nominal_sh = value;
            REG_BETA:    beta_sh = value[BETA_W-1:0];
            default:     ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thermistor(logic [OHMS_W-1:0] pu, logic [OHMS_W-1:0] nom,
                                  logic [OHMS_W-1:0] b);
        write_reg(REG_PULLUP, pu);
        write_reg(REG_NOMINAL, nom);
        write_reg(REG_BETA, b);
    endtask

    // One group of eight clustered around a center, clamped to the ADC range.
    task automatic queue_group(int center, int spread);
        int v;
        for (int i = 0; i < AVG_SAMPLES; i++)
        begin
            v = center + $urandom_range(2 * spread) - spread;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            pending_samples.push_back(v[SAMPLE_W-1:0]);
        end
    endtask

    task automatic queue_random(int n_items);
        int left;
        int sel;
        left = n_items;
        while (left > 0)
        begin
            sel = $urandom_range(9);
            if (sel < 7)
            begin
                queue_group($urandom_range(4095), $urandom_range(3) == 0 ? 300 : 8);
                left -= AVG_SAMPLES;
            end
            else if (sel == 7)
            begin
                queue_group($urandom_range(1) ? $urandom_range(3) : 4095 - $urandom_range(3), 2);
                left -= AVG_SAMPLES;
            end
            else
            begin
                pending_samples.push_back(SAMPLE_W'($urandom_range(4095)));
                left--;
            end
        end
    endtask

    task automatic run_phase(int src_pct, int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        while (pending_samples.size() != 0 || n_accepted != n_launched)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        pullup_sh = 20'd10000;
        nominal_sh = 20'd10000;
        beta_sh = 14'd3950;
        group_sum = '0;
        group_cnt = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed groups at reset settings: both ADC limits, then a mix of extremes.
        queue_group(0, 0);
        queue_group(4095, 0);
        pending_samples.push_back(12'hFFF);
        pending_samples.push_back(12'h000);
        pending_samples.push_back(12'hAAA);
        pending_samples.push_back(12'h555);
        pending_samples.push_back(12'd1);
        pending_samples.push_back(12'd4094);
        pending_samples.push_back(12'd2048);
        pending_samples.push_back(12'd2047);
        queue_group(1, 0);
        run_phase(0, 0);

        // Register extremes and ordinary settings across the idling mixes.
        set_thermistor(20'hFFFFF, 20'hFFFFF, 20'h3FFF);
        queue_group(4094, 0);
        queue_group(3000, 0);
        queue_random(80);
        run_phase(0, 0);

        set_thermistor(20'd1, 20'd1, 20'd1);
        queue_random(80);
        run_phase(79, 0);

        set_thermistor(20'd0, 20'd0, 20'd0);
        queue_random(40);
        run_phase(0, 79);

        set_thermistor(20'd10000, 20'd0, 20'd0);
        write_reg(REG_UNUSED, 20'hFFFFF);
        queue_random(40);
        run_phase(35, 35);

        set_thermistor(20'd4700, 20'd100000, 20'd3435);
        queue_random(80);
        run_phase(79, 0);

        set_thermistor(OHMS_W'($urandom_range(1048575)), OHMS_W'($urandom_range(200000)),
                       OHMS_W'($urandom_range(16383)));
        queue_random(80);
        run_phase(0, 79);

        set_thermistor(20'd10000, 20'd10000, 20'd3950);
        queue_random(100);
        run_phase(35, 35);

        $display("checked %0d results over %0d config writes", results_checked, cfg_writes);
        $display("status mix: ok %0d, adc limit %0d, r not positive %0d, saturated %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_ntc_average_and_temperature OK");
        else
            $display("tb_ntc_average_and_temperature NOT OK");
        $finish;
    end

endmodule

// ----- ntc_average_and_temperature.f -----
hdl/ntcat_pkg.sv
hdl/ntcat_div.sv
hdl/ntcat_datapath.sv
hdl/ntcat_ctrl.sv
hdl/ntc_average_and_temperature.sv
dv/tb_ntc_average_and_temperature.sv
